### rtl/assert_macros.svh
// Assertion macros for rc4_stream_cipher.sv, the RTL file that carries concurrent checks.
// No dependencies; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside of reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a condition never holds at a rising clock edge outside of reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

### rtl/rc4_pkg.sv
// Shared types and constants for the RC4 stream cipher block.
// Used by the controller, the datapath and the top level; no dependencies.
package rc4_pkg;

   localparam int BYTE_W      = 8;
   localparam int ADDR_W      = 8;
   localparam int TABLE_DEPTH = 256;
   localparam int KEY_W       = 64;

   // Controller states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_KS_RD_K,
      ST_KS_RD_J,
      ST_KS_WR_K,
      ST_KS_WR_J,
      ST_PG_RD_I,
      ST_PG_RD_J,
      ST_PG_WR_I,
      ST_PG_WR_J
   } ctrl_state_type;

   // Datapath operations, one per cycle.
   typedef enum logic [3:0] {
      DP_NOP,
      DP_CAPTURE,
      DP_CLEAR,
      DP_KS_RD_K,
      DP_KS_RD_J,
      DP_KS_WR_K,
      DP_KS_WR_J,
      DP_PG_RD_I,
      DP_PG_RD_J,
      DP_PG_WR_I,
      DP_PG_WR_J
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic ks_last;   // The key schedule is on its final swap step.
      logic rsp_free;  // The output register can take a new beat this cycle.
   } dp_status_type;

endpackage

### rtl/rc4_ctrl.sv
// Sequencing controller for the RC4 block: key schedule and output steps.
// Depends on rc4_pkg; drives the datapath through dp_cmd_type only.
module rc4_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_start_of_message,
   output logic                  req_stall,
   input  rc4_pkg::dp_status_type status,
   output rc4_pkg::dp_cmd_type   cmd
);
   import rc4_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd.op    = DP_NOP;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.op   = DP_CAPTURE;
               state_in = req_start_of_message ? ST_CLEAR : ST_PG_RD_I;
            end
         end
         ST_CLEAR: begin
            cmd.op   = DP_CLEAR;
            state_in = ST_KS_RD_K;
         end
         ST_KS_RD_K: begin
            cmd.op   = DP_KS_RD_K;
            state_in = ST_KS_RD_J;
         end
         ST_KS_RD_J: begin
            cmd.op   = DP_KS_RD_J;
            state_in = ST_KS_WR_K;
         end
         ST_KS_WR_K: begin
            cmd.op   = DP_KS_WR_K;
            state_in = ST_KS_WR_J;
         end
         ST_KS_WR_J: begin
            cmd.op   = DP_KS_WR_J;
            state_in = status.ks_last ? ST_PG_RD_I : ST_KS_RD_K;
         end
         ST_PG_RD_I: begin
            cmd.op   = DP_PG_RD_I;
            state_in = ST_PG_RD_J;
         end
         ST_PG_RD_J: begin
            cmd.op   = DP_PG_RD_J;
            state_in = ST_PG_WR_I;
         end
         ST_PG_WR_I: begin
            cmd.op   = DP_PG_WR_I;
            state_in = ST_PG_WR_J;
         end
         ST_PG_WR_J: begin
            // Hold here until the output register can take the beat.
            if (status.rsp_free) begin
               cmd.op   = DP_PG_WR_J;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### rtl/rc4_dpath.sv
// Datapath for the RC4 block: permutation memory, indices, key and output register.
// Depends on rc4_pkg; steered one operation per cycle by rc4_ctrl.
module rc4_dpath #(
   parameter int KEY_BYTES = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  rc4_pkg::dp_cmd_type         cmd,
   output rc4_pkg::dp_status_type      status,
   input  logic                        csr_write_enable,
   input  logic [rc4_pkg::KEY_W-1:0]   csr_write_data,
   input  logic [rc4_pkg::BYTE_W-1:0]  req_data_byte,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [rc4_pkg::BYTE_W-1:0]  rsp_out_byte
);
   import rc4_pkg::*;

   // The key period is kept within one to eight bytes.
   localparam int KEY_N     = (KEY_BYTES < 1) ? 1 : (KEY_BYTES > 8) ? 8 : KEY_BYTES;
   localparam int SEL_W     = (KEY_N > 1) ? $clog2(KEY_N) : 1;
   localparam int KEY_REG_W = KEY_N * BYTE_W;

   // Permutation table; an entry whose valid bit is clear reads as its own address.
   logic [BYTE_W-1:0]      mem [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] vld_ff;

   logic [KEY_REG_W-1:0] key_ff;
   logic [SEL_W-1:0]     sel_ff;
   logic [ADDR_W-1:0]    k_ff;
   logic [ADDR_W-1:0]    acc_ff;
   logic [ADDR_W-1:0]    i_ff;
   logic [ADDR_W-1:0]    j_ff;
   logic [BYTE_W-1:0]    si_ff;
   logic [BYTE_W-1:0]    sj_ff;
   logic [BYTE_W-1:0]    data_ff;
   logic [BYTE_W-1:0]    out_ff;
   logic                 out_vld_ff;

   logic [BYTE_W-1:0] a_data_ff, b_data_ff;
   logic              a_vld_ff, b_vld_ff;
   logic [ADDR_W-1:0] a_addr_ff, b_addr_ff;

   logic              rda_en, rdb_en, we;
   logic [ADDR_W-1:0] rda_addr, rdb_addr, waddr;
   logic [BYTE_W-1:0] wdata;
   logic [BYTE_W-1:0] a_val, b_val, key_byte, keystream;
   logic [ADDR_W-1:0] acc_in, i_in, j_in;
   logic              out_vld_in;

   assign a_val    = a_vld_ff ? a_data_ff : a_addr_ff;
   assign b_val    = b_vld_ff ? b_data_ff : b_addr_ff;
   assign key_byte = key_ff[sel_ff * BYTE_W +: BYTE_W];
   assign acc_in   = acc_ff + a_val + key_byte;
   assign i_in     = i_ff + 1'b1;
   assign j_in     = j_ff + a_val;

   // The keystream read was issued while S[i] was being written, so the swapped
   // entries are forwarded from the values held in si_ff and sj_ff.
   always_comb begin
      if (a_addr_ff == i_ff) begin
         keystream = sj_ff;
      end else if (a_addr_ff == j_ff) begin
         keystream = si_ff;
      end else begin
         keystream = a_val;
      end
   end

   always_comb begin
      rda_en   = 1'b0;
      rda_addr = k_ff;
      rdb_en   = 1'b0;
      rdb_addr = acc_in;
      we       = 1'b0;
      waddr    = k_ff;
      wdata    = b_val;
      case (cmd.op)
         DP_KS_RD_K: begin
            rda_en = 1'b1;
         end
         DP_KS_RD_J: begin
            rdb_en = 1'b1;
         end
         DP_KS_WR_K: begin
            we = 1'b1;
         end
         DP_KS_WR_J: begin
            we    = 1'b1;
            waddr = acc_ff;
            wdata = si_ff;
         end
         DP_PG_RD_I: begin
            rda_en   = 1'b1;
            rda_addr = i_in;
         end
         DP_PG_RD_J: begin
            rdb_en   = 1'b1;
            rdb_addr = j_in;
         end
         DP_PG_WR_I: begin
            we       = 1'b1;
            waddr    = i_ff;
            rda_en   = 1'b1;
            rda_addr = si_ff + b_val;
         end
         DP_PG_WR_J: begin
            we    = 1'b1;
            waddr = j_ff;
            wdata = si_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (rda_en) begin
         a_data_ff <= mem[rda_addr];
         a_vld_ff  <= vld_ff[rda_addr];
         a_addr_ff <= rda_addr;
      end
      if (rdb_en) begin
         b_data_ff <= mem[rdb_addr];
         b_vld_ff  <= vld_ff[rdb_addr];
         b_addr_ff <= rdb_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (cmd.op == DP_CLEAR) begin
         vld_ff <= '0;
      end else if (we) begin
         vld_ff[waddr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else if (csr_write_enable) begin
         key_ff <= csr_write_data[KEY_REG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         i_ff <= '0;
         j_ff <= '0;
      end else begin
         case (cmd.op)
            DP_CLEAR: begin
               i_ff <= '0;
               j_ff <= '0;
            end
            DP_PG_RD_I: begin
               i_ff <= i_in;
            end
            DP_PG_RD_J: begin
               j_ff <= j_in;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         DP_CAPTURE: begin
            data_ff <= req_data_byte;
         end
         DP_CLEAR: begin
            k_ff   <= '0;
            sel_ff <= '0;
            acc_ff <= '0;
         end
         DP_KS_RD_J: begin
            acc_ff <= acc_in;
            si_ff  <= a_val;
         end
         DP_KS_WR_J: begin
            k_ff   <= k_ff + 1'b1;
            sel_ff <= (sel_ff == SEL_W'(KEY_N - 1)) ? '0 : sel_ff + 1'b1;
         end
         DP_PG_RD_J: begin
            si_ff <= a_val;
         end
         DP_PG_WR_I: begin
            sj_ff <= b_val;
         end
         DP_PG_WR_J: begin
            out_ff <= data_ff ^ keystream;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      if (cmd.op == DP_PG_WR_J) begin
         out_vld_in = 1'b1;
      end else begin
         out_vld_in = out_vld_ff & rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
   end

   assign status.ks_last  = (k_ff == ADDR_W'(TABLE_DEPTH - 1));
   assign status.rsp_free = !out_vld_ff || !rsp_stall;
   assign rsp_valid       = out_vld_ff;
   assign rsp_out_byte    = out_ff;

endmodule

### rtl/rc4_stream_cipher.sv
// RC4 stream cipher top level: controller plus permutation datapath.
// A result beat is registered after its byte's output-generation steps; no new byte is taken
// until they end. A start-of-message byte first runs the key schedule: a clear step, then one
// swap per table entry, bound by the single write port of the 256-entry permutation memory.
// Synchronous active-high reset restores the identity table, zero i and j indices and a zero key.
`include "assert_macros.svh"

module rc4_stream_cipher #(
   parameter int KEY_BYTES = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   // Configuration port: the 64-bit key, taken whenever the write enable is high.
   input  logic                       csr_write_enable,
   input  logic [rc4_pkg::KEY_W-1:0]  csr_write_data,
   // Input channel: one data byte per beat and a start-of-message flag.
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [rc4_pkg::BYTE_W-1:0] req_data_byte,
   input  logic                       req_start_of_message,
   // Result channel: one transformed byte per input beat.
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [rc4_pkg::BYTE_W-1:0] rsp_out_byte
);
   import rc4_pkg::*;

   // The controller and datapath talk only through these two structs.
   dp_cmd_type    cmd;
   dp_status_type status;

   // The controller accepts a beat only from its idle state. A plain byte then walks
   // through four output-generation steps: read S[i], read S[j], write S[i] while
   // reading the keystream entry, and write S[j] while loading the output register.
   // A flagged byte first clears the table to the identity by dropping every entry's valid
   // bit, then runs 256 swap steps before its output-generation steps.
   rc4_ctrl u_ctrl (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_start_of_message (req_start_of_message),
      .req_stall            (req_stall),
      .status               (status),
      .cmd                  (cmd)
   );

   // The datapath owns the permutation memory, the key register and the output
   // register, which lets a finished beat wait while the next byte is taken.
   rc4_dpath #(
      .KEY_BYTES (KEY_BYTES)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte)
   );

   // After a beat is accepted the controller stalls the input in the next cycle.
   `ASSERT_CLK(a_busy_after_accept, clock, reset,
      (req_valid && !req_stall) |=> req_stall, "input accepted twice in a row")
   // A result beat appears only right after the final output-generation step.
   `ASSERT_CLK(a_rsp_from_final_step, clock, reset,
      $rose(rsp_valid) |-> $past(cmd.op == DP_PG_WR_J), "result beat without a finished step")
   // The output register is never loaded while it holds a stalled beat.
   `ASSERT_NEVER(a_no_overwrite, clock, reset,
      (cmd.op == DP_PG_WR_J) && rsp_valid && rsp_stall, "stalled result beat overwritten")

endmodule
